### design/media_frame_queue_iframe_drop_top_assert.svh
// Assertion macros used by the frame queue datapath.
`ifndef MEDIA_FRAME_QUEUE_IFRAME_DROP_TOP_ASSERT_SVH
`define MEDIA_FRAME_QUEUE_IFRAME_DROP_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MFQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MFQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/mfq_pkg.sv
// Types and codes of the frame descriptor queue.
package mfq_pkg;

    typedef enum logic [1:0] {
        FUNC_PUSH    = 2'd0,
        FUNC_PEEK    = 2'd1,
        FUNC_DISCARD = 2'd2,
        FUNC_POP     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_SIZE  = 2'd3
    } status_t;

    typedef enum logic {
        CTRL_IDLE = 1'b0,
        CTRL_EXEC = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic [31:0] tag;
        logic [63:0] time_stamp;
        logic [19:0] length;
        logic [31:0] handle;
    } slot_t;

    typedef struct packed {
        logic [31:0] out_tag;
        logic [63:0] out_time;
        logic [19:0] out_len;
        logic [31:0] out_handle;
        logic [31:0] drops_reported;
        logic        frame_dropped;
        status_t     status;
    } result_t;

    typedef struct packed {
        logic load;   // capture the accepted item
        logic exec;   // run the operation and load the result register
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;  // result register empty or being taken this cycle
    } dp_status_t;

endpackage

### design/mfq_ctrl.sv
// Controller state machine: sequences capture and execution of one item.
module mfq_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  mfq_pkg::dp_status_t  dp_status,
    output mfq_pkg::ctrl_cmd_t   cmd
);

    mfq_pkg::ctrl_state_t state_reg;
    mfq_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mfq_pkg::CTRL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            mfq_pkg::CTRL_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = mfq_pkg::CTRL_EXEC;
                end
            end
            mfq_pkg::CTRL_EXEC: begin
                // head slot read data is valid here; wait only for the result register
                if (dp_status.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = mfq_pkg::CTRL_IDLE;
                end
            end
            default: begin
                state_next = mfq_pkg::CTRL_IDLE;
            end
        endcase
    end

endmodule

### design/mfq_datapath.sv
// Datapath: slot memory, queue indices, skip/drop tracking and result register.
`include "media_frame_queue_iframe_drop_top_assert.svh"

module mfq_datapath #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mfq_pkg::ctrl_cmd_t   cmd,
    output mfq_pkg::dp_status_t  dp_status,
    input  logic [1:0]           in_func,
    input  logic                 in_is_video,
    input  logic                 in_is_iframe,
    input  logic [31:0]          in_data_handle,
    input  logic [19:0]          in_data_len,
    input  logic [63:0]          in_time_stamp,
    input  logic [31:0]          in_tag,
    input  logic [19:0]          in_buf_limit,
    output mfq_pkg::result_t     result,
    output logic                 result_valid,
    input  logic                 result_ready
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

    // captured item
    mfq_pkg::func_t func_reg;
    logic           video_reg;
    logic           iframe_reg;
    mfq_pkg::slot_t wslot_reg;
    logic [19:0]    limit_reg;

    // queue state
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic             skip_reg, skip_next;
    logic [31:0]      count_reg, count_next;

    // slot memory
    mfq_pkg::slot_t   mem [QUEUE_DEPTH];
    mfq_pkg::slot_t   rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_widx;

    mfq_pkg::result_t res_reg, res_next;
    logic             valid_reg;

    logic [IDX_W-1:0] wr_inc, wr_dec, rd_inc;
    logic             full, empty, drop;
    logic             rd_idx_ok, wr_idx_ok;

    assign wr_inc = (wr_idx_reg == IDX_LAST) ? '0 : wr_idx_reg + 1'b1;
    assign wr_dec = (wr_idx_reg == '0) ? IDX_LAST : wr_idx_reg - 1'b1;
    assign rd_inc = (rd_idx_reg == IDX_LAST) ? '0 : rd_idx_reg + 1'b1;
    assign full   = (wr_inc == rd_idx_reg);
    assign empty  = (rd_idx_reg == wr_idx_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg             <= mfq_pkg::func_t'(in_func);
            video_reg            <= in_is_video;
            iframe_reg           <= in_is_iframe;
            wslot_reg.handle     <= in_data_handle;
            wslot_reg.length     <= in_data_len;
            wslot_reg.time_stamp <= in_time_stamp;
            wslot_reg.tag        <= in_tag;
            limit_reg            <= in_buf_limit;
        end
    end

    always_comb begin
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        skip_next   = skip_reg;
        count_next  = count_reg;
        mem_we      = 1'b0;
        mem_widx    = wr_idx_reg;
        drop        = 1'b0;
        res_next    = '0;
        res_next.status = mfq_pkg::ST_OK;
        case (func_reg)
            mfq_pkg::FUNC_PUSH: begin
                if (full && !video_reg) begin
                    res_next.status = mfq_pkg::ST_FULL;
                end else if (video_reg && !iframe_reg && (full || skip_reg)) begin
                    drop                   = 1'b1;
                    skip_next              = 1'b1;
                    count_next             = count_reg + 32'd1;
                    res_next.frame_dropped = 1'b1;
                end else begin
                    // full I-frame replaces the newest entry
                    mem_widx    = full ? wr_dec : wr_idx_reg;
                    mem_we      = 1'b1;
                    wr_idx_next = full ? wr_idx_reg : wr_inc;
                    skip_next   = 1'b0;
                    if (skip_reg) begin
                        res_next.drops_reported = count_reg;
                        count_next              = '0;
                    end
                end
            end
            mfq_pkg::FUNC_DISCARD: begin
                if (empty) begin
                    res_next.status = mfq_pkg::ST_EMPTY;
                end else begin
                    rd_idx_next = rd_inc;
                end
            end
            mfq_pkg::FUNC_PEEK, mfq_pkg::FUNC_POP: begin
                if (empty) begin
                    res_next.status = mfq_pkg::ST_EMPTY;
                end else if (limit_reg < rd_data_reg.length) begin
                    res_next.status = mfq_pkg::ST_SIZE;
                end else begin
                    res_next.out_handle = rd_data_reg.handle;
                    res_next.out_len    = rd_data_reg.length;
                    res_next.out_time   = rd_data_reg.time_stamp;
                    res_next.out_tag    = rd_data_reg.tag;
                    if (func_reg == mfq_pkg::FUNC_POP) begin
                        rd_idx_next = rd_inc;
                    end
                end
            end
            default: begin
                res_next.status = mfq_pkg::ST_EMPTY;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            skip_reg   <= 1'b0;
            count_reg  <= '0;
        end else if (cmd.exec) begin
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
            skip_reg   <= skip_next;
            count_reg  <= count_next;
        end
    end

    // head read is registered; the index only moves on exec, so the data catches up in the cycle after it moves
    always_ff @(posedge aclk) begin
        if (cmd.exec && mem_we) begin
            mem[mem_widx] <= wslot_reg;
        end
        rd_data_reg <= mem[rd_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.exec) begin
            valid_reg <= 1'b1;
        end else if (result_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_reg <= res_next;
        end
    end

    assign result             = res_reg;
    assign result_valid       = valid_reg;
    assign dp_status.out_free = !valid_reg || result_ready;

    assign rd_idx_ok = ({1'b0, rd_idx_reg} < (IDX_W + 1)'(QUEUE_DEPTH));
    assign wr_idx_ok = ({1'b0, wr_idx_reg} < (IDX_W + 1)'(QUEUE_DEPTH));

    `MFQ_ASSERT_NOW(a_idx_range, aclk, aresetn, 1'b1, rd_idx_ok && wr_idx_ok,
        "queue index out of range")
    `MFQ_ASSERT_NEXT(a_drop_sets_skip, aclk, aresetn, cmd.exec && drop, skip_reg,
        "dropped frame did not set skip flag")
    `MFQ_ASSERT_NEXT(a_rd_idx_hold, aclk, aresetn, !cmd.exec, $stable(rd_idx_reg),
        "read index moved without an operation")
    `MFQ_ASSERT_NOW(a_empty_status, aclk, aresetn,
        cmd.exec && (res_next.status == mfq_pkg::ST_EMPTY), empty,
        "empty status reported on a non-empty queue")

endmodule

### design/media_frame_queue_iframe_drop_top.sv
// Top level of the frame descriptor queue with I-frame aware dropping.
// Usage:
//   Each slave item is one command: push a frame descriptor, peek, discard
//   or pop the head. Each command yields exactly one master item carrying
//   a status, a drop flag, the reported drop count and, for a successful
//   peek or pop, the head descriptor.
//   The queue holds at most QUEUE_DEPTH-1 descriptors in an internal slot
//   memory with a registered read port.
// Timing:
//   An item is accepted in IDLE and executed in EXEC once the result
//   register is free; its result appears on the master side the cycle after.
//   A new item is taken only in IDLE, after the previous one has executed;
//   the registered head-slot read puts the execute step after capture.
//   The result register decouples the sides: the next item is accepted while
//   a result still waits; its execution holds until the receiver takes it.
// Reset:
//   aresetn (synchronous, active low) empties the queue, clears the skip flag
//   and drop count, and drops any pending result. Slot contents are kept.
module media_frame_queue_iframe_drop_top #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: data_handle[31:0], data_len[51:32], time_stamp[115:52], tag[147:116],
    //        buf_limit[167:148]
    input  logic [167:0] s_tdata,
    // tuser: func[1:0], is_video[2], is_iframe[3]
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: drops_reported[31:0], out_handle[63:32], out_len[83:64],
    //        out_time[147:84], out_tag[179:148], zero[183:180]
    output logic [183:0] m_tdata,
    // tuser: status[1:0], frame_dropped[2]
    output logic [2:0]   m_tuser
);

    mfq_pkg::ctrl_cmd_t  cmd;
    mfq_pkg::dp_status_t dp_status;
    mfq_pkg::result_t    result;

    mfq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    mfq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .dp_status      (dp_status),
        .in_func        (s_tuser[1:0]),
        .in_is_video    (s_tuser[2]),
        .in_is_iframe   (s_tuser[3]),
        .in_data_handle (s_tdata[31:0]),
        .in_data_len    (s_tdata[51:32]),
        .in_time_stamp  (s_tdata[115:52]),
        .in_tag         (s_tdata[147:116]),
        .in_buf_limit   (s_tdata[167:148]),
        .result         (result),
        .result_valid   (m_tvalid),
        .result_ready   (m_tready)
    );

    assign m_tdata = {4'b0000, result.out_tag, result.out_time, result.out_len,
                      result.out_handle, result.drops_reported};
    assign m_tuser = {result.frame_dropped, result.status};

endmodule

### tb/testbench.sv
// Self-checking bench for the frame descriptor queue with I-frame aware dropping.
`timescale 1ns / 1ps

module testbench;

    localparam int DEPTH      = 8;
    localparam int STALL_MAX  = 2000;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_WAIT = 20;
    localparam int PHASE_LEN  = 300;

    typedef struct {
        mfq_pkg::func_t op;
        bit             video;
        bit             iframe;
        bit [31:0]      handle;
        bit [19:0]      len;
        bit [63:0]      stamp;
        bit [31:0]      tag;
        bit [19:0]      limit;
    } frame_cmd_t;

    typedef struct {
        mfq_pkg::status_t status;
        bit               dropped;
        bit [31:0]        drops;
        bit [31:0]        handle;
        bit [19:0]        len;
        bit [63:0]        stamp;
        bit [31:0]        tag;
    } frame_reply_t;

    logic         aclk;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [167:0] s_tdata  = '0;
    logic [3:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [183:0] m_tdata;
    logic [2:0]   m_tuser;

    media_frame_queue_iframe_drop_top #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    frame_cmd_t   cmd_backlog[$];
    frame_reply_t reply_due[$];
    int           mismatches = 0;
    int           send_idle_pct = 0;
    int           sink_stall_pct = 0;
    int           hold_req = 0;
    int           hold_seen = 0;
    int           hold_left = 0;
    int           quiet_cycles = 0;

    // shadow copy of the queue
    bit [31:0] shadow_handle[DEPTH];
    bit [19:0] shadow_len[DEPTH];
    bit [63:0] shadow_stamp[DEPTH];
    bit [31:0] shadow_tag[DEPTH];
    int        shadow_rd = 0;
    int        shadow_wr = 0;
    bit        shadow_skip = 1'b0;
    bit [31:0] shadow_drops = '0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic frame_reply_t frame_queue_apply(frame_cmd_t c);
        frame_reply_t r;
        bit           full;
        int           widx;
        r.status  = mfq_pkg::ST_OK;
        r.dropped = 1'b0;
        r.drops   = '0;
        r.handle  = '0;
        r.len     = '0;
        r.stamp   = '0;
        r.tag     = '0;
        if (c.op == mfq_pkg::FUNC_PUSH) begin
            full = ((shadow_wr + 1) % DEPTH) == shadow_rd;
            if (full && !c.video) begin
                r.status = mfq_pkg::ST_FULL;
            end else if (c.video && !c.iframe && (full || shadow_skip)) begin
                shadow_skip  = 1'b1;
                shadow_drops = shadow_drops + 1;
                r.dropped    = 1'b1;
            end else begin
                // an I-frame on a full queue replaces the newest entry
                widx = full ? (shadow_wr + DEPTH - 1) % DEPTH : shadow_wr;
                if (shadow_skip)
                    r.drops = shadow_drops;
                shadow_drops        = '0;
                shadow_skip         = 1'b0;
                shadow_handle[widx] = c.handle;
                shadow_len[widx]    = c.len;
                shadow_stamp[widx]  = c.stamp;
                shadow_tag[widx]    = c.tag;
                shadow_wr           = (widx + 1) % DEPTH;
            end
        end else if (shadow_rd == shadow_wr) begin
            r.status = mfq_pkg::ST_EMPTY;
        end else if (c.op == mfq_pkg::FUNC_DISCARD) begin
            shadow_rd = (shadow_rd + 1) % DEPTH;
        end else if (c.limit < shadow_len[shadow_rd]) begin
            r.status = mfq_pkg::ST_SIZE;
        end else begin
            r.handle = shadow_handle[shadow_rd];
            r.len    = shadow_len[shadow_rd];
            r.stamp  = shadow_stamp[shadow_rd];
            r.tag    = shadow_tag[shadow_rd];
            if (c.op == mfq_pkg::FUNC_POP)
                shadow_rd = (shadow_rd + 1) % DEPTH;
        end
        return r;
    endfunction

    function automatic frame_cmd_t mk_cmd(mfq_pkg::func_t op, bit video, bit iframe,
                                          bit [31:0] handle, bit [19:0] len,
                                          bit [63:0] stamp, bit [31:0] tag,
                                          bit [19:0] limit);
        frame_cmd_t c;
        c.op     = op;
        c.video  = video;
        c.iframe = iframe;
        c.handle = handle;
        c.len    = len;
        c.stamp  = stamp;
        c.tag    = tag;
        c.limit  = limit;
        return c;
    endfunction

    function automatic frame_cmd_t random_cmd(int push_pct);
        int             pick;
        mfq_pkg::func_t op;
        bit [19:0]      len;
        bit [19:0]      limit;
        pick = $urandom_range(0, 99);
        if (pick < push_pct)
            op = mfq_pkg::FUNC_PUSH;
        else if (pick < push_pct + (100 - push_pct) / 4)
            op = mfq_pkg::FUNC_PEEK;
        else if (pick < push_pct + (100 - push_pct) / 2)
            op = mfq_pkg::FUNC_DISCARD;
        else
            op = mfq_pkg::FUNC_POP;
        case ($urandom_range(0, 7))
            0:       len = 20'hFFFFF;
            1, 2:    len = 20'($urandom_range(0, 15));
            default: len = 20'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0, 1:    limit = 20'hFFFFF;
            2:       limit = '0;
            3:       limit = 20'($urandom_range(0, 15));
            default: limit = 20'($urandom);
        endcase
        return mk_cmd(op, 1'($urandom), $urandom_range(0, 3) == 0, $urandom, len,
                      {$urandom, $urandom}, $urandom, limit);
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // sender: holds the item until taken, may idle between items
    always @(posedge aclk) begin
        frame_cmd_t taken;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                taken = cmd_backlog.pop_front();
                reply_due.push_back(frame_queue_apply(taken));
            end
            if (!s_tvalid || s_tready) begin
                if (cmd_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cmd_backlog[0].limit, cmd_backlog[0].tag, cmd_backlog[0].stamp,
                                 cmd_backlog[0].len, cmd_backlog[0].handle};
                    s_tuser  <= {cmd_backlog[0].iframe, cmd_backlog[0].video, cmd_backlog[0].op};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus one long hold-off on request
    always @(posedge aclk) begin
        frame_reply_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (reply_due.size() == 0) begin
                    $error("result item with nothing expected: tuser %0h tdata %0h",
                           m_tuser, m_tdata);
                    mismatches++;
                end else begin
                    want = reply_due.pop_front();
                    check_field("status", want.status, m_tuser[1:0]);
                    check_field("frame_dropped", want.dropped, m_tuser[2]);
                    check_field("drops_reported", want.drops, m_tdata[31:0]);
                    check_field("out_handle", want.handle, m_tdata[63:32]);
                    check_field("out_len", want.len, m_tdata[83:64]);
                    check_field("out_time", want.stamp, m_tdata[147:84]);
                    check_field("out_tag", want.tag, m_tdata[179:148]);
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= $urandom_range(0, 99) >= sink_stall_pct;
            end
        end
    end

    // watchdog: no item moved on either side for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else if (cmd_backlog.size() > 0 || reply_due.size() > 0)
                quiet_cycles++;
            if (quiet_cycles >= STALL_MAX) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic run_random(int count);
        for (int n = 0; n < count; n++)
            // alternate fill-heavy and drain-heavy stretches to hit full and empty
            cmd_backlog.push_back(random_cmd(((n / 40) % 2 == 0) ? 75 : 30));
    endtask

    task automatic drain_all();
        while (cmd_backlog.size() > 0 || reply_due.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // empty queue on every read operation
        cmd_backlog.push_back(mk_cmd(mfq_pkg::FUNC_PEEK, 0, 0, 0, 0, 0, 0, 20'hFFFFF));
        cmd_backlog.push_back(mk_cmd(mfq_pkg::FUNC_POP, 0, 0, 0, 0, 0, 0, 20'hFFFFF));
        cmd_backlog.push_back(mk_cmd(mfq_pkg::FUNC_DISCARD, 0, 0, 0, 0, 0, 0, 0));
        // all-ones descriptor, buffer too small, then exact fits
        cmd_backlog.push_back(mk_cmd(mfq_pkg::FUNC_PUSH, 0, 1, '1, '1, '1, '1, '1));
        cmd_backlog.push_back(mk_cmd(mfq_pkg::FUNC_PEEK, 1, 1, '1, '1, '1, '1, 0));
        cmd_backlog.push_back(mk_cmd(mfq_pkg::FUNC_PEEK, 0, 0, 0, 0, 0, 0, 20'hFFFFF));
        cmd_backlog.push_back(mk_cmd(mfq_pkg::FUNC_POP, 0, 0, 0, 0, 0, 0, 20'hFFFFF));
        cmd_backlog.push_back(mk_cmd(mfq_pkg::FUNC_PUSH, 0, 0, 0, 0, 0, 0, 0));
        cmd_backlog.push_back(mk_cmd(mfq_pkg::FUNC_POP, 0, 0, 0, 0, 0, 0, 0));
        // fill to capacity, indices wrap
        for (int k = 0; k < DEPTH - 1; k++)
            cmd_backlog.push_back(mk_cmd(mfq_pkg::FUNC_PUSH, k % 2, k % 3 == 0, $urandom,
                                         20'($urandom), {$urandom, $urandom}, $urandom,
                                         20'($urandom)));
        // full: audio refused, non-I video dropped, skip persists after space opens
        cmd_backlog.push_back(mk_cmd(mfq_pkg::FUNC_PUSH, 0, 0, $urandom, 1, 1, 1, 0));
        cmd_backlog.push_back(mk_cmd(mfq_pkg::FUNC_PUSH, 1, 0, $urandom, 2, 2, 2, 0));
        cmd_backlog.push_back(mk_cmd(mfq_pkg::FUNC_PUSH, 1, 0, $urandom, 3, 3, 3, 0));
        cmd_backlog.push_back(mk_cmd(mfq_pkg::FUNC_PUSH, 0, 1, $urandom, 4, 4, 4, 0));
        cmd_backlog.push_back(mk_cmd(mfq_pkg::FUNC_DISCARD, 0, 0, 0, 0, 0, 0, 0));
        cmd_backlog.push_back(mk_cmd(mfq_pkg::FUNC_PUSH, 1, 0, $urandom, 5, 5, 5, 0));
        // audio write while skipping reports the drop count
        cmd_backlog.push_back(mk_cmd(mfq_pkg::FUNC_PUSH, 0, 0, 32'hA5A5_5A5A, 6, 6, 6, 0));
        // I-frame on a full queue overwrites the newest entry
        cmd_backlog.push_back(mk_cmd(mfq_pkg::FUNC_PUSH, 1, 1, 32'h1234_5678, 7, 7, 7, 0));
        cmd_backlog.push_back(mk_cmd(mfq_pkg::FUNC_POP, 0, 0, 0, 0, 0, 0, 20'hFFFFF));

        // back-to-back, with one long receiver hold while the sender keeps offering
        run_random(PHASE_LEN);
        hold_req++;
        drain_all();

        send_idle_pct  = 77;
        sink_stall_pct = 0;
        run_random(PHASE_LEN);
        drain_all();

        send_idle_pct  = 0;
        sink_stall_pct = 77;
        run_random(PHASE_LEN);
        drain_all();

        send_idle_pct  = 29;
        sink_stall_pct = 29;
        run_random(PHASE_LEN);
        drain_all();

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
